@@ rtl/bounded_laurent_poly_arith_top_macros.svh @@
// assertion macros for the checker file
// no dependencies
`ifndef BOUNDED_LAURENT_POLY_ARITH_TOP_MACROS_SVH
`define BOUNDED_LAURENT_POLY_ARITH_TOP_MACROS_SVH

// plain property under clock and reset
`define BLPA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// same-cycle implication
`define BLPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BLPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/blpa_pkg.sv @@
// shared types and constants for the bounded laurent polynomial arithmetic block
// no dependencies
package blpa_pkg;

   localparam int COEF_W = 32;
   localparam int DEG_W  = 6;
   localparam int OP_W   = 2;

   localparam logic [OP_W-1:0] OP_MUL = 2'd0;
   localparam logic [OP_W-1:0] OP_ADD = 2'd1;
   localparam logic [OP_W-1:0] OP_SUB = 2'd2;

   typedef struct packed {
      logic shift_a;
      logic shift_b;
      logic clear_acc;
      logic clear_store;
   } cell_ctrl_type;

endpackage

@@ rtl/blpa_cell.sv @@
// one coefficient cell: operand storage, product and partial sum stages
// depends on blpa_pkg
module blpa_cell
   import blpa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cell_ctrl_type     ctrl,
   input  logic              load_en,
   input  logic [COEF_W-1:0] load_a,
   input  logic [COEF_W-1:0] load_b,
   input  logic [COEF_W-1:0] a_next,
   input  logic [COEF_W-1:0] b_next,
   input  logic [COEF_W-1:0] s_next,
   input  logic [COEF_W-1:0] x,
   output logic [COEF_W-1:0] a_out,
   output logic [COEF_W-1:0] b_out,
   output logic [COEF_W-1:0] s_out
);

   logic [COEF_W-1:0] a_ff, a_in;
   logic [COEF_W-1:0] b_ff, b_in;
   logic [COEF_W-1:0] p_ff, p_in;
   logic [COEF_W-1:0] s_ff, s_in;

   always_comb begin
      a_in = a_ff;
      if (ctrl.clear_store) begin
         a_in = '0;
      end else if (load_en) begin
         a_in = load_a;
      end else if (ctrl.shift_a) begin
         a_in = a_next;
      end
   end

   always_comb begin
      b_in = b_ff;
      if (ctrl.clear_store) begin
         b_in = '0;
      end else if (load_en) begin
         b_in = load_b;
      end else if (ctrl.shift_b) begin
         b_in = b_next;
      end
   end

   assign p_in = ctrl.clear_acc ? '0 : a_ff * x;
   assign s_in = ctrl.clear_acc ? '0 : p_ff + s_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= '0;
         b_ff <= '0;
      end else begin
         a_ff <= a_in;
         b_ff <= b_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff <= p_in;
      s_ff <= s_in;
   end

   assign a_out = a_ff;
   assign b_out = b_ff;
   assign s_out = s_ff;

endmodule

@@ rtl/bounded_laurent_poly_arith_top.sv @@
// top level: truncated product, sum or difference of two laurent polynomials
// depends on blpa_pkg and blpa_cell
//
//   channel   ports                                         flow
//   request   start busy req_a_coef req_b_coef req_last_in  start & !busy
//   result    rsp_strobe rsp_result_coef rsp_degree         one cycle per strobe
//             rsp_last_out
//   csr       csr_we csr_wdata                              write when csr_we
//
// a request without last takes one cycle; it is stored in the cell at its position
// a last request starts a run: multiply keeps busy until the partial-sum chain has
// drained through all cells; add and subtract keep busy until every cell has shifted out
// results come one per cycle with no gaps; the last one shows while busy is already low
// reset clears the operands, the load count and the operation register
module bounded_laurent_poly_arith_top
   import blpa_pkg::*;
#(
   parameter int MAX_DEGREE = 15
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [COEF_W-1:0] req_a_coef,
   input  logic signed [COEF_W-1:0] req_b_coef,
   input  logic                     req_last_in,
   output logic                     rsp_strobe,
   output logic signed [COEF_W-1:0] rsp_result_coef,
   output logic signed [DEG_W-1:0]  rsp_degree,
   output logic                     rsp_last_out,
   input  logic                     csr_we,
   input  logic [OP_W-1:0]          csr_wdata
);

   localparam int SPAN  = 2 * MAX_DEGREE + 1;
   localparam int LC_W  = $clog2(SPAN + 1);
   localparam int CNT_W = $clog2(3 * MAX_DEGREE + 3);

   localparam logic [CNT_W-1:0] MUL_FIRST = CNT_W'(MAX_DEGREE + 2);
   localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(3 * MAX_DEGREE + 2);
   localparam logic [CNT_W-1:0] ADD_LAST  = CNT_W'(SPAN - 1);
   localparam logic [LC_W-1:0]  LC_FULL   = LC_W'(SPAN);
   localparam logic [DEG_W-1:0] DEG_START = DEG_W'(0) - DEG_W'(MAX_DEGREE);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_ADD  = 2'd2;

   logic [1:0]        state_ff, state_in;
   logic [OP_W-1:0]   op_ff;
   logic [LC_W-1:0]   load_count_ff, load_count_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DEG_W-1:0]  deg_ff, deg_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_last_ff, rsp_last_in;
   logic [COEF_W-1:0] rsp_coef_ff, rsp_coef_in;
   logic [DEG_W-1:0]  rsp_deg_ff, rsp_deg_in;

   cell_ctrl_type     ctrl;
   logic              accept;
   logic              is_addsub;
   logic [SPAN-1:0]   load_en;
   logic [COEF_W-1:0] a_q [SPAN+1];
   logic [COEF_W-1:0] b_q [SPAN+1];
   logic [COEF_W-1:0] s_q [SPAN+1];

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   assign is_addsub = (op_ff == OP_ADD) || (op_ff == OP_SUB);

   assign a_q[SPAN] = '0;
   assign b_q[SPAN] = '0;
   assign s_q[SPAN] = '0;

   for (genvar i = 0; i < SPAN; i++) begin : g_cell
      assign load_en[i] = accept && (load_count_ff == LC_W'(i));

      blpa_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .load_en (load_en[i]),
         .load_a  (req_a_coef),
         .load_b  (req_b_coef),
         .a_next  (a_q[i+1]),
         .b_next  (b_q[i+1]),
         .s_next  (s_q[i+1]),
         .x       (b_q[0]),
         .a_out   (a_q[i]),
         .b_out   (b_q[i]),
         .s_out   (s_q[i])
      );
   end

   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      cnt_in        = cnt_ff;
      deg_in        = deg_ff;
      rsp_valid_in  = 1'b0;
      rsp_last_in   = 1'b0;
      rsp_coef_in   = rsp_coef_ff;
      rsp_deg_in    = rsp_deg_ff;
      ctrl          = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (load_count_ff != LC_FULL) begin
                  load_count_in = load_count_ff + LC_W'(1);
               end
               if (req_last_in) begin
                  state_in       = is_addsub ? ST_ADD : ST_MUL;
                  cnt_in         = '0;
                  deg_in         = DEG_START;
                  ctrl.clear_acc = 1'b1;
               end
            end
         end
         ST_MUL: begin
            ctrl.shift_b = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            if (cnt_ff >= MUL_FIRST) begin
               rsp_valid_in = 1'b1;
               rsp_coef_in  = s_q[0];
               rsp_deg_in   = deg_ff;
               deg_in       = deg_ff + DEG_W'(1);
            end
            if (cnt_ff == MUL_LAST) begin
               rsp_last_in      = 1'b1;
               ctrl.clear_store = 1'b1;
               load_count_in    = '0;
               state_in         = ST_IDLE;
            end
         end
         ST_ADD: begin
            ctrl.shift_a = 1'b1;
            ctrl.shift_b = 1'b1;
            cnt_in       = cnt_ff + CNT_W'(1);
            rsp_valid_in = 1'b1;
            rsp_coef_in  = (op_ff == OP_SUB) ? a_q[0] - b_q[0] : a_q[0] + b_q[0];
            rsp_deg_in   = deg_ff;
            deg_in       = deg_ff + DEG_W'(1);
            if (cnt_ff == ADD_LAST) begin
               rsp_last_in      = 1'b1;
               ctrl.clear_store = 1'b1;
               load_count_in    = '0;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         op_ff         <= OP_MUL;
         load_count_ff <= '0;
         cnt_ff        <= '0;
         deg_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_last_ff   <= 1'b0;
      end else begin
         state_ff      <= state_in;
         load_count_ff <= load_count_in;
         cnt_ff        <= cnt_in;
         deg_ff        <= deg_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_last_ff   <= rsp_last_in;
         if (csr_we) begin
            op_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_coef_ff <= rsp_coef_in;
      rsp_deg_ff  <= rsp_deg_in;
   end

   assign rsp_strobe      = rsp_valid_ff;
   assign rsp_result_coef = rsp_coef_ff;
   assign rsp_degree      = rsp_deg_ff;
   assign rsp_last_out    = rsp_last_ff;

endmodule

@@ rtl/blpa_checker.sv @@
// port-level checks for the laurent polynomial arithmetic top level
// depends on blpa_pkg and bounded_laurent_poly_arith_top_macros.svh
`include "bounded_laurent_poly_arith_top_macros.svh"

module blpa_port_checker
   import blpa_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     rsp_strobe,
   input logic signed [DEG_W-1:0]  rsp_degree,
   input logic                     rsp_last_out
);

   // a run only begins from an accepted request
   `BLPA_ASSERT_IMP(a_busy_from_start, clock, reset, $rose(busy), $past(start), "busy rose without start")

   // results appear only as part of a run
   `BLPA_ASSERT_IMP(a_rsp_in_run, clock, reset, rsp_strobe, $past(busy), "result outside a run")

   // final result closes the run
   `BLPA_ASSERT_IMP(a_last_ends, clock, reset, rsp_strobe && rsp_last_out, !busy, "busy after final result")

   // results stream back to back with rising degree
   `BLPA_ASSERT_NXT(a_deg_step, clock, reset, rsp_strobe && !rsp_last_out, rsp_strobe && (rsp_degree == $past(rsp_degree) + 6'sd1), "degree sequence broken")

endmodule

bind bounded_laurent_poly_arith_top blpa_port_checker u_blpa_port_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_degree   (rsp_degree),
   .rsp_last_out (rsp_last_out)
);
